// ===== sv/bsbp_pkg.sv =====
package bsbp_pkg;

  localparam int POOL_DEPTH_DEF  = 16;
  localparam int HANDLE_BITS_DEF = 16;

  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int CFG_W    = 5;
  localparam int COUNT_W  = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DUMP   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [KEY_W-1:0]   key;
    logic [HANDLE_W-1:0]       handle;
  } in_item_t;

  typedef struct packed {
    logic                      entry_valid;
    logic signed [KEY_W-1:0]   entry_key;
    logic [HANDLE_W-1:0]       entry_handle;
    logic                      evicted_valid;
    logic [HANDLE_W-1:0]       evicted_handle;
    logic [COUNT_W-1:0]        entry_count;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic dump_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic res_last;
  } dp_status_t;

endpackage

// ===== sv/bsbp_ctrl.sv =====
module bsbp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bsbp_pkg::dp_status_t status,
  output bsbp_pkg::ctrl_cmd_t  cmd
);
  import bsbp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.res_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.dump_step = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/bsbp_datapath.sv =====
module bsbp_datapath #(
  parameter int POOL_DEPTH  = bsbp_pkg::POOL_DEPTH_DEF,
  parameter int HANDLE_BITS = bsbp_pkg::HANDLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bsbp_pkg::CFG_W-1:0]  cfg_data,
  input  bsbp_pkg::in_item_t          in_data,
  input  bsbp_pkg::ctrl_cmd_t         cmd,
  output bsbp_pkg::dp_status_t        status,
  output bsbp_pkg::out_item_t         out_data
);
  import bsbp_pkg::*;

  localparam int CW = $clog2(POOL_DEPTH + 1);

  logic [CFG_W-1:0]        max_entries;
  logic [CW-1:0]           count;
  logic [CW-1:0]           dump_left;
  in_item_t                item;
  out_item_t               res;

  logic signed [KEY_W-1:0] keys [POOL_DEPTH];
  logic [HANDLE_BITS-1:0]  hdls [POOL_DEPTH];

  logic signed [KEY_W-1:0] ins_keys [POOL_DEPTH];
  logic [HANDLE_BITS-1:0]  ins_hdls [POOL_DEPTH];
  logic signed [KEY_W-1:0] rot_keys [POOL_DEPTH];
  logic [HANDLE_BITS-1:0]  rot_hdls [POOL_DEPTH];

  logic [CW-1:0]           lim;
  logic [CW-1:0]           cnt_t;
  logic [POOL_DEPTH-1:0]   goes_after;
  logic [HANDLE_BITS-1:0]  item_h;
  logic                    tail_take;
  logic [HANDLE_BITS-1:0]  tail_h;
  logic                    overflow;
  logic                    rotate;
  logic [CW-1:0]           count_next;
  logic [CW-1:0]           dump_left_next;
  out_item_t               res_next;

  assign item_h = HANDLE_BITS'(item.handle);

  always_comb begin
    if (max_entries == '0 || 32'(max_entries) > POOL_DEPTH) begin
      lim = CW'(POOL_DEPTH);
    end else begin
      lim = CW'(max_entries);
    end
    cnt_t    = (count > lim) ? lim : count;
    overflow = (cnt_t == lim);
  end

  // Insertion: every cell at or beyond the insertion point takes its
  // left neighbor, and the first such cell takes the new entry.
  always_comb begin
    tail_take = 1'b0;
    tail_h    = '0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      goes_after[i] = (CW'(i) >= cnt_t) || (item.key < keys[i]);
    end
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (!goes_after[i]) begin
        ins_keys[i] = keys[i];
        ins_hdls[i] = hdls[i];
      end else if (i == 0) begin
        ins_keys[i] = item.key;
        ins_hdls[i] = item_h;
      end else if (!goes_after[(i == 0) ? 0 : i - 1]) begin
        ins_keys[i] = item.key;
        ins_hdls[i] = item_h;
      end else begin
        ins_keys[i] = keys[(i == 0) ? 0 : i - 1];
        ins_hdls[i] = hdls[(i == 0) ? 0 : i - 1];
      end
      if (CW'(i + 1) == cnt_t) begin
        tail_take = goes_after[i];
        tail_h    = hdls[i];
      end
    end
  end

  // Dump: the held entries rotate left by one, so the head is always next.
  always_comb begin
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (CW'(i + 1) == cnt_t) begin
        rot_keys[i] = keys[0];
        rot_hdls[i] = hdls[0];
      end else if (CW'(i + 1) < cnt_t) begin
        rot_keys[i] = keys[(i + 1 < POOL_DEPTH) ? i + 1 : i];
        rot_hdls[i] = hdls[(i + 1 < POOL_DEPTH) ? i + 1 : i];
      end else begin
        rot_keys[i] = keys[i];
        rot_hdls[i] = hdls[i];
      end
    end
  end

  always_comb begin
    res_next       = res;
    count_next     = count;
    dump_left_next = dump_left;
    rotate         = 1'b0;
    if (cmd.exec) begin
      res_next      = '0;
      res_next.last = 1'b1;
      count_next    = cnt_t;
      case (item.opcode)
        OP_INSERT: begin
          count_next            = overflow ? cnt_t : CW'(cnt_t + 1'b1);
          res_next.entry_valid  = 1'b1;
          res_next.entry_key    = goes_after[0] ? item.key : keys[0];
          res_next.entry_handle = HANDLE_W'(goes_after[0] ? item_h : hdls[0]);
          if (overflow) begin
            res_next.evicted_valid  = 1'b1;
            res_next.evicted_handle = HANDLE_W'(tail_take ? tail_h : item_h);
          end
        end
        OP_DUMP: begin
          if (cnt_t != '0) begin
            rotate                = 1'b1;
            res_next.entry_valid  = 1'b1;
            res_next.entry_key    = keys[0];
            res_next.entry_handle = HANDLE_W'(hdls[0]);
            res_next.last         = (cnt_t == CW'(1));
            dump_left_next        = CW'(cnt_t - 1'b1);
          end
        end
        OP_CLEAR: begin
          count_next = '0;
        end
        default: begin
          if (cnt_t != '0) begin
            res_next.entry_valid  = 1'b1;
            res_next.entry_key    = keys[0];
            res_next.entry_handle = HANDLE_W'(hdls[0]);
          end
        end
      endcase
      res_next.entry_count = COUNT_W'(count_next);
    end else if (cmd.dump_step) begin
      rotate                = 1'b1;
      res_next.entry_valid  = 1'b1;
      res_next.entry_key    = keys[0];
      res_next.entry_handle = HANDLE_W'(hdls[0]);
      res_next.last         = (dump_left == CW'(1));
      dump_left_next        = CW'(dump_left - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= '0;
      count       <= '0;
      dump_left   <= '0;
    end else begin
      if (cfg_we) begin
        max_entries <= cfg_data;
      end
      count     <= count_next;
      dump_left <= dump_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    res <= res_next;
    if (cmd.exec && item.opcode == OP_INSERT) begin
      keys <= ins_keys;
      hdls <= ins_hdls;
    end else if (rotate) begin
      keys <= rot_keys;
      hdls <= rot_hdls;
    end
  end

  assign out_data        = res;
  assign status.res_last = res.last;

endmodule

// ===== sv/bounded_sorted_best_pool_core.sv =====
// Channel  Direction  Payload            Handshake
// in       input      in_item_t          in_valid / in_ready
// out      output     out_item_t         out_valid / out_ready
// cfg      input      max_entries        cfg_we, no wait
//
// An item is accepted in the idle state, executed in the next cycle, and its
// first result is offered in the cycle after that from the output register.
// A dump then gives one beat per cycle while out_ready stays high; the block
// takes the next item in the cycle after the final beat is taken.
// Reset is synchronous and empties the pool; stalls on out_ready hold the beat.
module bounded_sorted_best_pool_core #(
  parameter int POOL_DEPTH  = bsbp_pkg::POOL_DEPTH_DEF,
  parameter int HANDLE_BITS = bsbp_pkg::HANDLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bsbp_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bsbp_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [bsbp_pkg::CFG_W-1:0]  cfg_data
);
  import bsbp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bsbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bsbp_datapath #(
    .POOL_DEPTH  (POOL_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ===== sv/bsbp_checker.sv =====
module bsbp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input bsbp_pkg::in_item_t          in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input bsbp_pkg::out_item_t         out_data,
  input logic                        cfg_we,
  input logic [bsbp_pkg::CFG_W-1:0]  cfg_data
);
  import bsbp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Output beat changed while stalled.");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid)
    else $error("Item accepted while a result was pending.");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.entry_valid |-> out_data.entry_count == '0)
    else $error("Empty result with nonzero count.");

  a_evict_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.evicted_valid |-> out_data.entry_valid && out_data.last)
    else $error("Eviction reported on a non-final or empty result.");

  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.evicted_valid |-> out_data.evicted_handle == '0)
    else $error("Evicted handle nonzero without eviction.");

endmodule

bind bounded_sorted_best_pool_core bsbp_checker u_bsbp_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import bsbp_pkg::*;

  localparam int IDLE_LIMIT       = 2000;
  localparam int RANDOM_PER_PHASE = 37;

  class pool_scoreboard;
    logic signed [KEY_W-1:0] keys [POOL_DEPTH_DEF+1];
    logic [HANDLE_W-1:0]     handles [POOL_DEPTH_DEF+1];
    int unsigned             held;
    logic [CFG_W-1:0]        max_entries;
    out_item_t               beats_due [$];
    int                      errors;
    int                      beats_checked;
    int                      evictions;

    function new();
      held          = 0;
      max_entries   = '0;
      errors        = 0;
      beats_checked = 0;
      evictions     = 0;
    endfunction

    function void set_limit(logic [CFG_W-1:0] v);
      max_entries = v;
    endfunction

    function int unsigned limit_now();
      if (max_entries == 0 || max_entries > POOL_DEPTH_DEF) begin
        return POOL_DEPTH_DEF;
      end
      return max_entries;
    endfunction

    function int pending();
      return beats_due.size();
    endfunction

    function void queue_beat(bit ev, logic signed [KEY_W-1:0] k, logic [HANDLE_W-1:0] h,
                             bit xv, logic [HANDLE_W-1:0] xh, bit lst);
      out_item_t r;
      r.entry_valid    = ev;
      r.entry_key      = k;
      r.entry_handle   = h;
      r.evicted_valid  = xv;
      r.evicted_handle = xh;
      r.entry_count    = held[COUNT_W-1:0];
      r.last           = lst;
      beats_due.insert(beats_due.size(), r);
    endfunction

    function void push_best(bit xv, logic [HANDLE_W-1:0] xh);
      if (held > 0) begin
        queue_beat(1'b1, keys[0], handles[0], xv, xh, 1'b1);
      end else begin
        queue_beat(1'b0, '0, '0, xv, xh, 1'b1);
      end
    endfunction

    function void note_item(in_item_t it);
      int unsigned         lim;
      int unsigned         pos;
      int unsigned         i;
      bit                  xv;
      logic [HANDLE_W-1:0] xh;
      lim = limit_now();
      xv  = 1'b0;
      xh  = '0;
      // A lowered limit trims the tail silently before the item is handled.
      if (held > lim) begin
        held = lim;
      end
      case (it.opcode)
        OP_INSERT: begin
          pos = 0;
          while (pos < held && !(it.key < keys[pos])) begin
            pos++;
          end
          for (i = held; i > pos; i--) begin
            keys[i]    = keys[i-1];
            handles[i] = handles[i-1];
          end
          keys[pos]    = it.key;
          handles[pos] = it.handle;
          held++;
          if (held > lim) begin
            held--;
            xv = 1'b1;
            xh = handles[held];
            evictions++;
          end
          push_best(xv, xh);
        end
        OP_DUMP: begin
          if (held == 0) begin
            queue_beat(1'b0, '0, '0, 1'b0, '0, 1'b1);
          end else begin
            for (i = 0; i < held; i++) begin
              queue_beat(1'b1, keys[i], handles[i], 1'b0, '0, (i + 1 == held));
            end
          end
        end
        OP_CLEAR: begin
          held = 0;
          push_best(1'b0, '0);
        end
        default: begin
          push_best(1'b0, '0);
        end
      endcase
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_beat(out_item_t got);
      out_item_t want;
      if (beats_due.size() == 0) begin
        report("result beat arrived with nothing expected");
        return;
      end
      want = beats_due.pop_front();
      beats_checked++;
      if (got.entry_valid !== want.entry_valid)
        report($sformatf("entry_valid %0b, expected %0b",
                         got.entry_valid, want.entry_valid));
      if (got.entry_key !== want.entry_key)
        report($sformatf("entry_key %0d, expected %0d", got.entry_key, want.entry_key));
      if (got.entry_handle !== want.entry_handle)
        report($sformatf("entry_handle %h, expected %h",
                         got.entry_handle, want.entry_handle));
      if (got.evicted_valid !== want.evicted_valid)
        report($sformatf("evicted_valid %0b, expected %0b",
                         got.evicted_valid, want.evicted_valid));
      if (got.evicted_handle !== want.evicted_handle)
        report($sformatf("evicted_handle %h, expected %h",
                         got.evicted_handle, want.evicted_handle));
      if (got.entry_count !== want.entry_count)
        report($sformatf("entry_count %0d, expected %0d",
                         got.entry_count, want.entry_count));
      if (got.last !== want.last)
        report($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_data  = '0;

  pool_scoreboard sb;
  int burst_left       = 0;
  int items_sent       = 0;
  int settings_written = 0;
  int idle_cycles      = 0;
  int ready_mode       = 0;
  int ready_timer      = 0;
  int ready_tick       = 0;
  int phase_limits [8];

  always #5 clk = ~clk;

  bounded_sorted_best_pool_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_beat(out_data);
    end
  end

  always @(negedge clk) begin
    if (ready_timer == 0) begin
      ready_mode  = $urandom_range(0, 3);
      ready_timer = $urandom_range(20, 80);
    end else begin
      ready_timer--;
    end
    ready_tick++;
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= (ready_tick % 3 == 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL bounded_sorted_best_pool_core");
        $finish;
      end
    end
  end

  task send_item(in_item_t it);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task send_op(logic [1:0] op, logic signed [KEY_W-1:0] k, logic [HANDLE_W-1:0] h);
    in_item_t it;
    it.opcode = op;
    it.key    = k;
    it.handle = h;
    send_item(it);
  endtask

  // The limit is only written once every expected beat is out and the core is idle.
  task settle_and_write(logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(v);
    settings_written++;
    burst_left = 0;
  endtask

  function in_item_t random_item();
    in_item_t it;
    int       r;
    r         = $urandom_range(0, 99);
    it.handle = HANDLE_W'($urandom_range(0, 65535));
    it.key    = $urandom;
    if (r < 72) begin
      it.opcode = OP_INSERT;
    end else if (r < 84) begin
      it.opcode = OP_DUMP;
    end else if (r < 88) begin
      it.opcode = OP_CLEAR;
    end else begin
      it.opcode = OP_QUERY;
    end
    case ($urandom_range(0, 5))
      0, 1:    it.key = int'($urandom_range(0, 8)) - 4;
      2:       it.key = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      3:       it.key = int'($urandom_range(0, 6)) <<< 16;
      default: ;
    endcase
    return it;
  endfunction

  initial begin
    sb = new();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    settle_and_write(5'd0);
    send_op(OP_DUMP,   32'sd0,          16'h0000);
    send_op(OP_QUERY,  32'sd0,          16'h0000);
    send_op(OP_CLEAR,  32'sd0,          16'h0000);
    send_op(OP_INSERT, 32'sh7FFF_FFFF,  16'hFFFF);
    send_op(OP_INSERT, 32'sh8000_0000,  16'h0000);
    send_op(OP_INSERT, 32'sd0,          16'h0001);
    send_op(OP_INSERT, 32'sd0,          16'h0002);
    send_op(OP_INSERT, -32'sd1,         16'h0003);
    send_op(OP_QUERY,  32'sd0,          16'h0000);
    send_op(OP_DUMP,   32'sd0,          16'h0000);
    send_op(OP_CLEAR,  32'sd0,          16'h0000);

    settle_and_write(5'd3);
    send_op(OP_INSERT, 32'sd10,         16'h0010);
    send_op(OP_INSERT, 32'sd20,         16'h0020);
    send_op(OP_INSERT, 32'sd30,         16'h0030);
    send_op(OP_INSERT, 32'sd5,          16'h0005);
    send_op(OP_INSERT, 32'sd20,         16'h0021);
    send_op(OP_INSERT, 32'sh7FFF_FFFF,  16'hAAAA);
    send_op(OP_DUMP,   32'sd0,          16'h0000);

    settle_and_write(5'd1);
    send_op(OP_QUERY,  32'sd0,          16'h0000);
    send_op(OP_INSERT, -32'sd5,         16'h5555);
    send_op(OP_DUMP,   32'sd0,          16'h0000);

    settle_and_write(5'd31);
    send_op(OP_INSERT, 32'sd7,          16'h1234);
    send_op(OP_DUMP,   32'sd0,          16'h0000);

    phase_limits = '{16, 1, 17, 2, 31, 0, 0, 0};
    phase_limits[6] = $urandom_range(0, 31);
    phase_limits[7] = $urandom_range(3, 15);
    foreach (phase_limits[p]) begin
      settle_and_write(phase_limits[p][CFG_W-1:0]);
      repeat (RANDOM_PER_PHASE) send_item(random_item());
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items under %0d limit settings; %0d result beats checked.",
             items_sent, settings_written, sb.beats_checked);
    $display("Predicted %0d evictions; %0d mismatches found.", sb.evictions, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS bounded_sorted_best_pool_core");
    end else begin
      $display("FAIL bounded_sorted_best_pool_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bsbp_pkg.sv
sv/bsbp_ctrl.sv
sv/bsbp_datapath.sv
sv/bounded_sorted_best_pool_core.sv
sv/bsbp_checker.sv
verif/tb.sv
